>>> rtl/rsrq_pkg.sv
// Shared types, codes and constants of the reserved slot request queue.
package rsrq_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam logic [15:0] TIMEOUT_RESET = 16'd10;

    localparam logic [1:0] FUNC_RESERVE = 2'd0;
    localparam logic [1:0] FUNC_SUBMIT  = 2'd1;
    localparam logic [1:0] FUNC_PROCESS = 2'd2;
    localparam logic [1:0] FUNC_TICK    = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NONE   = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    typedef logic [2:0] rsrq_res_t;

    localparam rsrq_res_t RES_RESERVE = 3'd0;
    localparam rsrq_res_t RES_SUBMIT  = 3'd1;
    localparam rsrq_res_t RES_PROCESS = 3'd2;
    localparam rsrq_res_t RES_NONE    = 3'd3;
    localparam rsrq_res_t RES_REJECT  = 3'd4;
    localparam rsrq_res_t RES_TICK    = 3'd5;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] client_id;
        logic [7:0]  slot_index;
        logic [30:0] request_value;
    } rsrq_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot_out;
        logic [15:0] client_out;
        logic [30:0] request_out;
        logic [4:0]  queued_count;
    } rsrq_result_t;

    typedef struct packed {
        logic      load;
        logic      step;
        logic      rd_sub;
        logic      rd_hit;
        logic      fin;
        rsrq_res_t res;
    } rsrq_cmd_t;

    typedef struct packed {
        logic [1:0] func;
        logic       range_ok;
        logic       empty;
        logic       hit;
        logic       last_miss;
        logic       sub_ok;
    } rsrq_stat_t;

endpackage

>>> rtl/reserved_slot_request_queue.sv
// Top level of the reserved slot request queue: controller plus datapath.
//
//  channel   | handshake                 | payload        | beat taken when
//  ----------+---------------------------+----------------+--------------------------
//  command   | start / busy              | item           | start && !busy
//  result    | result_valid (strobe)     | result         | every cycle result_valid
//  config    | cfg_valid / cfg_ready     | cfg_data       | cfg_valid && cfg_ready
//
//  Tick and submit finish without a scan; reserve and process scan up to SLOTS slots;
//  the scan checks one slot a cycle through the registered stamp memory read.
//  The result strobe rises the cycle after the command's final state and busy drops with it,
//  so the next command beat can be taken while the result is shown.
//  Reset clears all slot flags, the cursor, tick counter and pending count at once.
//  cfg_ready is always high; the result receiver cannot stall.
module reserved_slot_request_queue #(
    parameter int SLOTS = rsrq_pkg::SLOTS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  rsrq_pkg::rsrq_item_t   item,
    output logic                   result_valid,
    output rsrq_pkg::rsrq_result_t result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);

    rsrq_pkg::rsrq_cmd_t  cmd;
    rsrq_pkg::rsrq_stat_t stat;

    assign cfg_ready = 1'b1;

    rsrq_controller u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    rsrq_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .cmd          (cmd),
        .stat         (stat),
        .result       (result),
        .result_valid (result_valid)
    );

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted command did not make the block busy");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result strobe without a command in flight");

    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    a_none_clean: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == rsrq_pkg::ST_NONE
        |-> result.client_out == '0 && result.request_out == '0 && result.slot_out == '0)
        else $error("empty or full result carries stale payload");

endmodule

>>> rtl/rsrq_datapath.sv
// Slot flags, slot memories, scan pipeline, counters and result register.
module rsrq_datapath #(
    parameter int SLOTS = rsrq_pkg::SLOTS_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsrq_pkg::rsrq_item_t   item,
    input  logic                   cfg_valid,
    input  logic [15:0]            cfg_data,
    input  rsrq_pkg::rsrq_cmd_t    cmd,
    output rsrq_pkg::rsrq_stat_t   stat,
    output rsrq_pkg::rsrq_result_t result,
    output logic                   result_valid
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);
    localparam logic [8:0]    SLOT_LIMIT = 9'(SLOTS);
    localparam logic [CW-1:0] SLOT_CNT   = CW'(SLOTS);
    localparam logic [CW-1:0] LAST_CNT   = CW'(SLOTS - 1);
    localparam logic [IW-1:0] LAST_IDX   = IW'(SLOTS - 1);

    rsrq_pkg::rsrq_item_t   item_reg;
    rsrq_pkg::rsrq_result_t result_reg;
    rsrq_pkg::rsrq_result_t result_next;
    logic                   result_valid_reg;

    logic [15:0]       timeout_reg;
    logic [31:0]       now_reg;
    logic [IW-1:0]     cursor_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [SLOTS-1:0]  pending_reg;
    logic [SLOTS-1:0]  owned_reg;
    logic [SLOTS-1:0]  live_reg;

    logic [IW-1:0]     s_reg;
    logic [CW-1:0]     cnt_reg;
    logic              cmp_valid_reg;
    logic              cmp_last_reg;
    logic [IW-1:0]     cmp_s_reg;
    logic [IW-1:0]     hit_s_reg;
    logic [31:0]       stamp_rd_reg;
    logic [15:0]       owner_rd_reg;
    logic [30:0]       request_rd_reg;

    logic [15:0]       owner_mem   [SLOTS];
    logic [30:0]       request_mem [SLOTS];
    logic [31:0]       stamp_mem   [SLOTS];

    logic [IW-1:0]     sub_s;
    logic [IW-1:0]     rd_addr;
    logic [31:0]       elapsed;
    logic              slot_free;
    logic              hit;

    assign sub_s     = item_reg.slot_index[IW-1:0];
    assign rd_addr   = cmd.rd_hit ? cmp_s_reg : sub_s;
    assign elapsed   = now_reg - stamp_rd_reg;
    assign slot_free = !pending_reg[cmp_s_reg]
                     && (!live_reg[cmp_s_reg] || elapsed >= {16'b0, timeout_reg});
    assign hit       = cmp_valid_reg && ((item_reg.func == rsrq_pkg::FUNC_PROCESS)
                     ? pending_reg[cmp_s_reg] : slot_free);

    always_comb
    begin
        stat.func      = item_reg.func;
        stat.range_ok  = {1'b0, item_reg.slot_index} < SLOT_LIMIT;
        stat.empty     = count_reg == '0;
        stat.hit       = hit;
        stat.last_miss = cmp_valid_reg && cmp_last_reg && !hit;
        stat.sub_ok    = owned_reg[sub_s] && !pending_reg[sub_s]
                       && (owner_rd_reg == item_reg.client_id);
    end

    always_comb
    begin
        count_next = count_reg;
        if (cmd.fin)
        begin
            if (cmd.res == rsrq_pkg::RES_SUBMIT)
            begin
                count_next = count_reg + CW'(1);
            end
            else if (cmd.res == rsrq_pkg::RES_PROCESS)
            begin
                count_next = count_reg - CW'(1);
            end
        end
    end

    always_comb
    begin
        result_next = '0;
        result_next.queued_count = 5'(count_next);
        unique case (cmd.res)
            rsrq_pkg::RES_RESERVE:
            begin
                result_next.status   = rsrq_pkg::ST_OK;
                result_next.slot_out = 4'(cmp_s_reg);
            end
            rsrq_pkg::RES_SUBMIT:
            begin
                result_next.status   = rsrq_pkg::ST_OK;
                result_next.slot_out = 4'(sub_s);
            end
            rsrq_pkg::RES_PROCESS:
            begin
                result_next.status      = rsrq_pkg::ST_OK;
                result_next.slot_out    = 4'(hit_s_reg);
                result_next.client_out  = owner_rd_reg;
                result_next.request_out = request_rd_reg;
            end
            rsrq_pkg::RES_NONE:
            begin
                result_next.status = rsrq_pkg::ST_NONE;
            end
            rsrq_pkg::RES_REJECT:
            begin
                result_next.status = rsrq_pkg::ST_REJECT;
            end
            default:
            begin
                result_next.status = rsrq_pkg::ST_OK;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg      <= rsrq_pkg::TIMEOUT_RESET;
            now_reg          <= '0;
            cursor_reg       <= '0;
            count_reg        <= '0;
            pending_reg      <= '0;
            owned_reg        <= '0;
            live_reg         <= '0;
            s_reg            <= '0;
            cnt_reg          <= '0;
            cmp_valid_reg    <= 1'b0;
            cmp_last_reg     <= 1'b0;
            cmp_s_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                timeout_reg <= cfg_data;
            end
            result_valid_reg <= cmd.fin;
            count_reg        <= count_next;
            if (cmd.load)
            begin
                s_reg         <= cursor_reg;
                cnt_reg       <= '0;
                cmp_valid_reg <= 1'b0;
            end
            else if (cmd.step)
            begin
                if (cnt_reg < SLOT_CNT)
                begin
                    s_reg         <= (s_reg == LAST_IDX) ? '0 : s_reg + IW'(1);
                    cnt_reg       <= cnt_reg + CW'(1);
                    cmp_valid_reg <= 1'b1;
                    cmp_last_reg  <= cnt_reg == LAST_CNT;
                    cmp_s_reg     <= s_reg;
                end
                else
                begin
                    cmp_valid_reg <= 1'b0;
                end
            end
            if (cmd.fin)
            begin
                case (cmd.res)
                    rsrq_pkg::RES_RESERVE:
                    begin
                        owned_reg[cmp_s_reg] <= 1'b1;
                        live_reg[cmp_s_reg]  <= 1'b1;
                    end
                    rsrq_pkg::RES_SUBMIT:
                    begin
                        pending_reg[sub_s] <= 1'b1;
                        live_reg[sub_s]    <= 1'b0;
                    end
                    rsrq_pkg::RES_PROCESS:
                    begin
                        pending_reg[hit_s_reg] <= 1'b0;
                        owned_reg[hit_s_reg]   <= 1'b0;
                        live_reg[hit_s_reg]    <= 1'b0;
                        cursor_reg             <= hit_s_reg;
                    end
                    rsrq_pkg::RES_TICK:
                    begin
                        now_reg <= now_reg + 32'd1;
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // payload and slot memories
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= item;
        end
        if (cmd.step)
        begin
            stamp_rd_reg <= stamp_mem[s_reg];
        end
        if (cmd.rd_sub || cmd.rd_hit)
        begin
            owner_rd_reg   <= owner_mem[rd_addr];
            request_rd_reg <= request_mem[rd_addr];
        end
        if (cmd.rd_hit)
        begin
            hit_s_reg <= cmp_s_reg;
        end
        if (cmd.fin && cmd.res == rsrq_pkg::RES_RESERVE)
        begin
            owner_mem[cmp_s_reg] <= item_reg.client_id;
            stamp_mem[cmp_s_reg] <= now_reg;
        end
        if (cmd.fin && cmd.res == rsrq_pkg::RES_SUBMIT)
        begin
            request_mem[sub_s] <= item_reg.request_value;
        end
        if (cmd.fin)
        begin
            result_reg <= result_next;
        end
    end

    assign result       = result_reg;
    assign result_valid = result_valid_reg;

endmodule

>>> rtl/rsrq_controller.sv
// Sequencing state machine of the reserved slot request queue.
module rsrq_controller (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  rsrq_pkg::rsrq_stat_t stat,
    output rsrq_pkg::rsrq_cmd_t  cmd,
    output logic                 busy
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DISPATCH = 3'd1;
    localparam logic [2:0] S_SCAN     = 3'd2;
    localparam logic [2:0] S_SUBCHK   = 3'd3;
    localparam logic [2:0] S_SERVE    = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (stat.func)
                    rsrq_pkg::FUNC_RESERVE:
                    begin
                        state_next = S_SCAN;
                    end
                    rsrq_pkg::FUNC_SUBMIT:
                    begin
                        if (stat.range_ok)
                        begin
                            cmd.rd_sub = 1'b1;
                            state_next = S_SUBCHK;
                        end
                        else
                        begin
                            cmd.fin    = 1'b1;
                            cmd.res    = rsrq_pkg::RES_REJECT;
                            state_next = S_IDLE;
                        end
                    end
                    rsrq_pkg::FUNC_PROCESS:
                    begin
                        if (stat.empty)
                        begin
                            cmd.fin    = 1'b1;
                            cmd.res    = rsrq_pkg::RES_NONE;
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                    default:
                    begin
                        cmd.fin    = 1'b1;
                        cmd.res    = rsrq_pkg::RES_TICK;
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_SCAN:
            begin
                cmd.step = 1'b1;
                if (stat.hit)
                begin
                    if (stat.func == rsrq_pkg::FUNC_PROCESS)
                    begin
                        cmd.rd_hit = 1'b1;
                        state_next = S_SERVE;
                    end
                    else
                    begin
                        cmd.fin    = 1'b1;
                        cmd.res    = rsrq_pkg::RES_RESERVE;
                        state_next = S_IDLE;
                    end
                end
                else if (stat.last_miss)
                begin
                    cmd.fin    = 1'b1;
                    cmd.res    = rsrq_pkg::RES_NONE;
                    state_next = S_IDLE;
                end
            end
            S_SUBCHK:
            begin
                cmd.fin    = 1'b1;
                cmd.res    = stat.sub_ok ? rsrq_pkg::RES_SUBMIT : rsrq_pkg::RES_REJECT;
                state_next = S_IDLE;
            end
            S_SERVE:
            begin
                cmd.fin    = 1'b1;
                cmd.res    = rsrq_pkg::RES_PROCESS;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = state_reg != S_IDLE;

endmodule
